// ===== rtl/dfa_token_lexer_macros.svh =====
// Assertion macros shared by the lexer's checker.
`ifndef DFA_TOKEN_LEXER_MACROS_SVH
`define DFA_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dfa_tl_pkg.sv =====
package dfa_tl_pkg;

   // Longest token length that is counted; the count saturates there.
   localparam int MAX_TOKEN_LEN = 255;
   localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255);

   // Leading characters of a token that are kept for keyword and operator matching.
   localparam int PREFIX_DEPTH = 6;
   localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);

   // Character classes.
   typedef enum logic [3:0] {
      CLS_BLANK  = 4'd0,
      CLS_DIGIT  = 4'd1,
      CLS_DOT    = 4'd2,
      CLS_LETTER = 4'd3,
      CLS_OPER   = 4'd4,
      CLS_SEP    = 4'd5,
      CLS_SQUOTE = 4'd6,
      CLS_DQUOTE = 4'd7,
      CLS_EOT    = 4'd8,
      CLS_BAD    = 4'd9
   } cls_type;

   // Lexer states; ST_DONE and ST_NONE only appear as table outcomes.
   typedef enum logic [3:0] {
      ST_START      = 4'd0,
      ST_IDENT      = 4'd1,
      ST_INT        = 4'd2,
      ST_FLOAT      = 4'd3,
      ST_OPER       = 4'd4,
      ST_SEP        = 4'd5,
      ST_CHAR_OPEN  = 4'd6,
      ST_CHAR_BODY  = 4'd7,
      ST_CHAR_CLOSE = 4'd8,
      ST_STR_BODY   = 4'd9,
      ST_STR_CLOSE  = 4'd10,
      ST_DOT        = 4'd11,
      ST_DONE       = 4'd12,
      ST_NONE       = 4'd13
   } state_type;

   localparam int NUM_STATES  = 12;
   localparam int NUM_CLASSES = 9;

   // Token kinds.
   localparam logic [3:0] KIND_IDENT   = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_INT     = 4'd2;
   localparam logic [3:0] KIND_FLOAT   = 4'd3;
   localparam logic [3:0] KIND_OPER    = 4'd4;
   localparam logic [3:0] KIND_SEP     = 4'd5;
   localparam logic [3:0] KIND_CHAR    = 4'd6;
   localparam logic [3:0] KIND_STRING  = 4'd7;
   localparam logic [3:0] KIND_DOT     = 4'd8;

   // Token codes.
   localparam logic [4:0] CODE_NONE   = 5'd0;
   localparam logic [4:0] KW_INT      = 5'd1;
   localparam logic [4:0] KW_VOID     = 5'd2;
   localparam logic [4:0] KW_RETURN   = 5'd3;
   localparam logic [4:0] KW_CONST    = 5'd4;
   localparam logic [4:0] KW_MAIN     = 5'd5;
   localparam logic [4:0] KW_STRUCT   = 5'd6;
   localparam logic [4:0] OP_PLUS     = 5'd7;
   localparam logic [4:0] OP_MINUS    = 5'd8;
   localparam logic [4:0] OP_STAR     = 5'd9;
   localparam logic [4:0] OP_SLASH    = 5'd10;
   localparam logic [4:0] OP_PERCENT  = 5'd11;
   localparam logic [4:0] OP_ASSIGN   = 5'd12;
   localparam logic [4:0] OP_GT       = 5'd13;
   localparam logic [4:0] OP_LT       = 5'd14;
   localparam logic [4:0] OP_EQ       = 5'd15;
   localparam logic [4:0] OP_LE       = 5'd16;
   localparam logic [4:0] OP_GE       = 5'd17;
   localparam logic [4:0] OP_NE       = 5'd18;
   localparam logic [4:0] OP_AND      = 5'd19;
   localparam logic [4:0] OP_OR       = 5'd20;
   localparam logic [4:0] SEP_LPAREN  = 5'd21;
   localparam logic [4:0] SEP_RPAREN  = 5'd22;
   localparam logic [4:0] SEP_LBRACE  = 5'd23;
   localparam logic [4:0] SEP_RBRACE  = 5'd24;
   localparam logic [4:0] SEP_SEMI    = 5'd25;
   localparam logic [4:0] SEP_COMMA   = 5'd26;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
   localparam logic [1:0] ERR_NO_TRANS = 2'd2;
   localparam logic [1:0] ERR_BAD_OPER = 2'd3;

   // Match results from the prefix matcher.
   typedef struct packed {
      logic [4:0] kw_code;
      logic [4:0] op_code;
      logic [4:0] sep_code;
   } match_type;

   // Transition table, one row per state, one column per character class.
   localparam state_type NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_DONE},
      '{ST_START, ST_IDENT, ST_DOT, ST_IDENT, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_INT, ST_FLOAT, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_FLOAT, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_NONE},
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_DONE},
      '{ST_NONE, ST_CHAR_BODY, ST_NONE, ST_CHAR_BODY, ST_NONE, ST_NONE, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_CHAR_CLOSE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_NONE, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_NONE, ST_STR_BODY, ST_STR_BODY, ST_STR_BODY, ST_NONE, ST_NONE, ST_NONE,
        ST_STR_CLOSE, ST_NONE},
      '{ST_START, ST_NONE, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_NONE, ST_NONE, ST_NONE, ST_IDENT, ST_NONE, ST_NONE, ST_NONE,
        ST_NONE, ST_NONE}
   };

   // Bit k set: a character of class k ends the token held in that state.
   localparam logic [NUM_CLASSES-1:0] EMIT_MASK [NUM_STATES] = '{
      9'h000, 9'h035, 9'h031, 9'h031, 9'h0EB, 9'h1FB,
      9'h000, 9'h000, 9'h031, 9'h000, 9'h031, 9'h008
   };

   // Sort one character into its class.
   function automatic cls_type classify(input logic [7:0] c);
      cls_type cls;
      case (c) inside
         " ", "\n", "\t":                     cls = CLS_BLANK;
         ["0":"9"]:                           cls = CLS_DIGIT;
         ".":                                 cls = CLS_DOT;
         "_", ["a":"z"], ["A":"Z"]:           cls = CLS_LETTER;
         "+", "-", "*", "/", "!", "=", "<", ">", "&", "|":
                                              cls = CLS_OPER;
         "{", "}", "(", ")", ";", ",":        cls = CLS_SEP;
         "'":                                 cls = CLS_SQUOTE;
         "\"":                                cls = CLS_DQUOTE;
         "$":                                 cls = CLS_EOT;
         default:                             cls = CLS_BAD;
      endcase
      return cls;
   endfunction

endpackage

// ===== rtl/dfa_tl_match.sv =====
module dfa_tl_match (
   input  logic [7:0]             prefix [dfa_tl_pkg::PREFIX_DEPTH],
   input  logic [7:0]             length,
   output dfa_tl_pkg::match_type  match
);

   // Keyword lookup: length and kept characters must both agree.
   always_comb begin
      match.kw_code = dfa_tl_pkg::CODE_NONE;
      if (length == 8'd3 && {prefix[0], prefix[1], prefix[2]} == "int") begin
         match.kw_code = dfa_tl_pkg::KW_INT;
      end else if (length == 8'd4 &&
                   {prefix[0], prefix[1], prefix[2], prefix[3]} == "void") begin
         match.kw_code = dfa_tl_pkg::KW_VOID;
      end else if (length == 8'd6 && {prefix[0], prefix[1], prefix[2], prefix[3],
                                      prefix[4], prefix[5]} == "return") begin
         match.kw_code = dfa_tl_pkg::KW_RETURN;
      end else if (length == 8'd5 && {prefix[0], prefix[1], prefix[2], prefix[3],
                                      prefix[4]} == "const") begin
         match.kw_code = dfa_tl_pkg::KW_CONST;
      end else if (length == 8'd4 &&
                   {prefix[0], prefix[1], prefix[2], prefix[3]} == "main") begin
         match.kw_code = dfa_tl_pkg::KW_MAIN;
      end else if (length == 8'd6 && {prefix[0], prefix[1], prefix[2], prefix[3],
                                      prefix[4], prefix[5]} == "struct") begin
         match.kw_code = dfa_tl_pkg::KW_STRUCT;
      end
   end

   // Operator lookup: one- and two-character operators only.
   always_comb begin
      match.op_code = dfa_tl_pkg::CODE_NONE;
      if (length == 8'd1) begin
         case (prefix[0])
            "+":     match.op_code = dfa_tl_pkg::OP_PLUS;
            "-":     match.op_code = dfa_tl_pkg::OP_MINUS;
            "*":     match.op_code = dfa_tl_pkg::OP_STAR;
            "/":     match.op_code = dfa_tl_pkg::OP_SLASH;
            "%":     match.op_code = dfa_tl_pkg::OP_PERCENT;
            "=":     match.op_code = dfa_tl_pkg::OP_ASSIGN;
            ">":     match.op_code = dfa_tl_pkg::OP_GT;
            "<":     match.op_code = dfa_tl_pkg::OP_LT;
            default: match.op_code = dfa_tl_pkg::CODE_NONE;
         endcase
      end else if (length == 8'd2) begin
         case ({prefix[0], prefix[1]})
            "==":    match.op_code = dfa_tl_pkg::OP_EQ;
            "<=":    match.op_code = dfa_tl_pkg::OP_LE;
            ">=":    match.op_code = dfa_tl_pkg::OP_GE;
            "!=":    match.op_code = dfa_tl_pkg::OP_NE;
            "&&":    match.op_code = dfa_tl_pkg::OP_AND;
            "||":    match.op_code = dfa_tl_pkg::OP_OR;
            default: match.op_code = dfa_tl_pkg::CODE_NONE;
         endcase
      end
   end

   // Separator lookup on the first character.
   always_comb begin
      match.sep_code = dfa_tl_pkg::CODE_NONE;
      if (length != 8'd0) begin
         case (prefix[0])
            "(":     match.sep_code = dfa_tl_pkg::SEP_LPAREN;
            ")":     match.sep_code = dfa_tl_pkg::SEP_RPAREN;
            "{":     match.sep_code = dfa_tl_pkg::SEP_LBRACE;
            "}":     match.sep_code = dfa_tl_pkg::SEP_RBRACE;
            ";":     match.sep_code = dfa_tl_pkg::SEP_SEMI;
            ",":     match.sep_code = dfa_tl_pkg::SEP_COMMA;
            default: match.sep_code = dfa_tl_pkg::CODE_NONE;
         endcase
      end
   end

endmodule

// ===== rtl/dfa_token_lexer.sv =====
// Channel   Direction  Handshake               Beat contents
// req       in         req_valid / req_ready   req_char_code
// rsp       out        rsp_valid / rsp_ready   token valid, kind, code, length, error, end
//
// One character beat per cycle is sustained while the result side takes its beats; a
// character passes through the input register, then through the table lookup and
// prefix match into the result register.
// Synchronous active-high reset returns the lexer to the start state with no
// beats held. A stalled result holds its beat; the input register keeps taking
// a character while the result register drains.
module dfa_token_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_token_valid,
   output logic [3:0] rsp_token_kind,
   output logic [4:0] rsp_token_code,
   output logic [7:0] rsp_token_length,
   output logic [1:0] rsp_error_code,
   output logic       rsp_end_of_text
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;

   // Lexer state.
   dfa_tl_pkg::state_type state_ff, state_in;
   logic [7:0]            len_ff, len_in;
   logic [7:0]            prefix_ff [dfa_tl_pkg::PREFIX_DEPTH];
   logic                  prefix_we;
   logic [dfa_tl_pkg::PREFIX_IDX_W-1:0] prefix_idx;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       tok_valid_ff, tok_valid_in;
   logic [3:0] kind_ff, kind_in;
   logic [4:0] code_ff, code_in;
   logic [7:0] length_ff, length_in;
   logic [1:0] err_ff, err_in;
   logic       eot_ff, eot_in;
   logic       has_rsp;

   logic                  fire;
   dfa_tl_pkg::cls_type   cls;
   dfa_tl_pkg::cls_type   cls_idx;
   dfa_tl_pkg::state_type st_idx;
   dfa_tl_pkg::state_type nx;
   logic                  emit;
   logic [7:0]            len_base;
   dfa_tl_pkg::match_type match;

   // Prefix matcher for keywords, operators and separators.
   dfa_tl_match u_match (
      .prefix (prefix_ff),
      .length (len_ff),
      .match  (match)
   );

   // Flow control: the held character is processed once the result slot frees.
   assign fire        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_comb begin
      if (fire) begin
         rsp_valid_in = has_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Table lookup; illegal indexes are steered to safe rows and columns.
   always_comb begin
      cls     = dfa_tl_pkg::classify(char_ff);
      cls_idx = (cls == dfa_tl_pkg::CLS_BAD) ? dfa_tl_pkg::CLS_BLANK : cls;
      st_idx  = (state_ff > dfa_tl_pkg::ST_DOT) ? dfa_tl_pkg::ST_START : state_ff;
      nx      = dfa_tl_pkg::NEXT_TAB[st_idx][cls_idx];
      emit    = dfa_tl_pkg::EMIT_MASK[st_idx][cls_idx];
   end

   // Next state and result for the character in the input register.
   always_comb begin
      has_rsp      = 1'b0;
      tok_valid_in = 1'b0;
      kind_in      = dfa_tl_pkg::KIND_IDENT;
      code_in      = dfa_tl_pkg::CODE_NONE;
      length_in    = 8'd0;
      err_in       = dfa_tl_pkg::ERR_NONE;
      eot_in       = 1'b0;
      state_in     = state_ff;
      len_in       = len_ff;
      len_base     = len_ff;
      prefix_we    = 1'b0;
      prefix_idx   = len_ff[dfa_tl_pkg::PREFIX_IDX_W-1:0];

      if (cls == dfa_tl_pkg::CLS_BAD) begin
         has_rsp  = 1'b1;
         err_in   = dfa_tl_pkg::ERR_BAD_CHAR;
         state_in = dfa_tl_pkg::ST_START;
         len_in   = 8'd0;
      end else if (emit && st_idx == dfa_tl_pkg::ST_OPER &&
                   match.op_code == dfa_tl_pkg::CODE_NONE) begin
         has_rsp  = 1'b1;
         err_in   = dfa_tl_pkg::ERR_BAD_OPER;
         state_in = dfa_tl_pkg::ST_START;
         len_in   = 8'd0;
      end else if (nx == dfa_tl_pkg::ST_NONE) begin
         has_rsp  = 1'b1;
         err_in   = dfa_tl_pkg::ERR_NO_TRANS;
         state_in = dfa_tl_pkg::ST_START;
         len_in   = 8'd0;
      end else begin
         // Report the finished token and restart the count.
         if (emit) begin
            has_rsp      = 1'b1;
            tok_valid_in = 1'b1;
            length_in    = len_ff;
            len_base     = 8'd0;
            unique case (st_idx)
               dfa_tl_pkg::ST_IDENT: begin
                  code_in = match.kw_code;
                  kind_in = (match.kw_code != dfa_tl_pkg::CODE_NONE) ?
                            dfa_tl_pkg::KIND_KEYWORD : dfa_tl_pkg::KIND_IDENT;
               end
               dfa_tl_pkg::ST_INT:        kind_in = dfa_tl_pkg::KIND_INT;
               dfa_tl_pkg::ST_FLOAT:      kind_in = dfa_tl_pkg::KIND_FLOAT;
               dfa_tl_pkg::ST_OPER: begin
                  kind_in = dfa_tl_pkg::KIND_OPER;
                  code_in = match.op_code;
               end
               dfa_tl_pkg::ST_SEP: begin
                  kind_in = dfa_tl_pkg::KIND_SEP;
                  code_in = match.sep_code;
               end
               dfa_tl_pkg::ST_CHAR_CLOSE: kind_in = dfa_tl_pkg::KIND_CHAR;
               dfa_tl_pkg::ST_STR_CLOSE:  kind_in = dfa_tl_pkg::KIND_STRING;
               default:                   kind_in = dfa_tl_pkg::KIND_DOT;
            endcase
         end

         if (nx == dfa_tl_pkg::ST_DONE) begin
            has_rsp  = 1'b1;
            eot_in   = 1'b1;
            state_in = dfa_tl_pkg::ST_START;
            len_in   = 8'd0;
         end else begin
            state_in   = nx;
            len_in     = len_base;
            prefix_idx = len_base[dfa_tl_pkg::PREFIX_IDX_W-1:0];
            // Blanks and quotes are not part of the token text.
            if (cls != dfa_tl_pkg::CLS_BLANK && cls != dfa_tl_pkg::CLS_SQUOTE &&
                cls != dfa_tl_pkg::CLS_DQUOTE) begin
               prefix_we = (len_base < 8'(dfa_tl_pkg::PREFIX_DEPTH));
               if (len_base < dfa_tl_pkg::LEN_CAP) begin
                  len_in = len_base + 8'd1;
               end
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= dfa_tl_pkg::ST_START;
         len_ff       <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
            len_ff   <= len_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_code;
      end
      if (fire && prefix_we) begin
         prefix_ff[prefix_idx] <= char_ff;
      end
      if (fire && has_rsp) begin
         tok_valid_ff <= tok_valid_in;
         kind_ff      <= kind_in;
         code_ff      <= code_in;
         length_ff    <= length_in;
         err_ff       <= err_in;
         eot_ff       <= eot_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_valid  = tok_valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_code   = code_ff;
   assign rsp_token_length = length_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_end_of_text  = eot_ff;

endmodule

// ===== rtl/dfa_tl_checker.sv =====
`include "dfa_token_lexer_macros.svh"

module dfa_tl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_char_code,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_token_valid,
   input logic [3:0] rsp_token_kind,
   input logic [4:0] rsp_token_code,
   input logic [7:0] rsp_token_length,
   input logic [1:0] rsp_error_code,
   input logic       rsp_end_of_text
);

   // A stalled result beat holds its contents.
   `DFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_valid) && $stable(rsp_token_kind) && $stable(rsp_token_code) && $stable(rsp_token_length) && $stable(rsp_error_code) && $stable(rsp_end_of_text), "result beat changed while stalled")

   // A beat always reports a token, an error or the end of text.
   `DFA_ASSERT_IMPLY(a_rsp_useful, clock, reset, rsp_valid, rsp_token_valid || rsp_end_of_text || rsp_error_code != dfa_tl_pkg::ERR_NONE, "empty result beat")

   // Errors never come with a token or an end marker.
   `DFA_ASSERT_IMPLY(a_err_alone, clock, reset, rsp_valid && rsp_error_code != dfa_tl_pkg::ERR_NONE, !rsp_token_valid && !rsp_end_of_text, "error beat carries a token")

   // Without a token the token fields are clear.
   `DFA_ASSERT_IMPLY(a_no_token_clear, clock, reset, rsp_valid && !rsp_token_valid, rsp_token_kind == dfa_tl_pkg::KIND_IDENT && rsp_token_code == dfa_tl_pkg::CODE_NONE && rsp_token_length == 8'd0, "token fields set without a token")

endmodule

bind dfa_token_lexer dfa_tl_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dfa_tl_pkg::*;

   // One result beat as the lexer reports it.
   typedef struct packed {
      logic       token_valid;
      logic [3:0] token_kind;
      logic [4:0] token_code;
      logic [7:0] token_length;
      logic [1:0] error_code;
      logic       end_of_text;
   } token_beat_t;

   // One row of the opening table; pinned rows carry their own expected beat.
   typedef struct packed {
      logic [7:0]  ch;
      logic        pinned;
      logic        has_beat;
      token_beat_t beat;
   } stim_row_t;

   localparam token_beat_t NO_BEAT       = '0;
   localparam token_beat_t BEAT_EOT      = '{end_of_text: 1'b1, default: '0};
   localparam token_beat_t BEAT_BAD_CHAR = '{error_code: ERR_BAD_CHAR, default: '0};
   localparam token_beat_t BEAT_NO_TRANS = '{error_code: ERR_NO_TRANS, default: '0};
   localparam token_beat_t BEAT_BAD_OPER = '{error_code: ERR_BAD_OPER, default: '0};

   localparam int N_OPENING    = 26;
   localparam int RANDOM_ITEMS = 1400;

   localparam string LETTERS    = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string DIGITS     = "0123456789";
   localparam string ALNUM      = {LETTERS, DIGITS};
   localparam string BODY       = {LETTERS, DIGITS, "."};
   localparam string OPS_SINGLE = "+-*/=><";
   localparam string SEPARATORS = "(){};,";
   localparam string BLANKS     = " \n\t";

   // Directed opening: reset extremes, all errors, all token kinds but float, table repairs.
   localparam stim_row_t OPENING_ROWS [N_OPENING] = '{
      '{"$",   1'b1, 1'b1, BEAT_EOT},
      '{8'h00, 1'b1, 1'b1, BEAT_BAD_CHAR},
      '{8'hff, 1'b1, 1'b1, BEAT_BAD_CHAR},
      '{"!",   1'b1, 1'b0, NO_BEAT},
      '{" ",   1'b1, 1'b1, BEAT_BAD_OPER},
      '{"\"",  1'b0, 1'b0, NO_BEAT},
      '{"a",   1'b0, 1'b0, NO_BEAT},
      '{"\"",  1'b0, 1'b0, NO_BEAT},
      '{"(",   1'b0, 1'b0, NO_BEAT},
      '{"+",   1'b0, 1'b0, NO_BEAT},
      '{"9",   1'b0, 1'b0, NO_BEAT},
      '{"<",   1'b0, 1'b0, NO_BEAT},
      '{"=",   1'b0, 1'b0, NO_BEAT},
      '{")",   1'b0, 1'b0, NO_BEAT},
      '{"$",   1'b0, 1'b0, NO_BEAT},
      '{"x",   1'b0, 1'b0, NO_BEAT},
      '{".",   1'b0, 1'b0, NO_BEAT},
      '{"i",   1'b0, 1'b0, NO_BEAT},
      '{"n",   1'b0, 1'b0, NO_BEAT},
      '{"t",   1'b0, 1'b0, NO_BEAT},
      '{" ",   1'b0, 1'b0, NO_BEAT},
      '{"'",   1'b0, 1'b0, NO_BEAT},
      '{"c",   1'b0, 1'b0, NO_BEAT},
      '{"'",   1'b0, 1'b0, NO_BEAT},
      '{",",   1'b0, 1'b0, NO_BEAT},
      '{".",   1'b1, 1'b1, BEAT_NO_TRANS}
   };

   // Next state for each lexer state and character class.
   localparam state_type TOKEN_NEXT [NUM_STATES][NUM_CLASSES] = '{
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_DONE},
      '{ST_START, ST_IDENT, ST_DOT, ST_IDENT, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_INT, ST_FLOAT, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_FLOAT, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_NONE},
      '{ST_START, ST_INT, ST_NONE, ST_IDENT, ST_OPER, ST_SEP, ST_CHAR_OPEN,
        ST_STR_BODY, ST_DONE},
      '{ST_NONE, ST_CHAR_BODY, ST_NONE, ST_CHAR_BODY, ST_NONE, ST_NONE,
        ST_NONE, ST_NONE, ST_NONE},
      '{ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_NONE, ST_CHAR_CLOSE,
        ST_NONE, ST_NONE},
      '{ST_START, ST_NONE, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_NONE, ST_STR_BODY, ST_STR_BODY, ST_STR_BODY, ST_NONE, ST_NONE,
        ST_NONE, ST_STR_CLOSE, ST_NONE},
      '{ST_START, ST_NONE, ST_NONE, ST_NONE, ST_OPER, ST_SEP, ST_NONE,
        ST_NONE, ST_NONE},
      '{ST_NONE, ST_NONE, ST_NONE, ST_IDENT, ST_NONE, ST_NONE, ST_NONE,
        ST_NONE, ST_NONE}
   };

   // Bit k set: a character of class k closes the token held in that state.
   localparam logic [NUM_CLASSES-1:0] TOKEN_CLOSES [NUM_STATES] = '{
      9'h000, 9'h035, 9'h031, 9'h031, 9'h0eb, 9'h1fb,
      9'h000, 9'h000, 9'h031, 9'h000, 9'h031, 9'h008
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_char_code = 8'h00;
   logic       rsp_ready     = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_token_valid;
   logic [3:0] rsp_token_kind;
   logic [4:0] rsp_token_code;
   logic [7:0] rsp_token_length;
   logic [1:0] rsp_error_code;
   logic       rsp_end_of_text;

   // Pinned expectation that travels with the character beat.
   logic        pin_on   = 1'b0;
   logic        pin_has  = 1'b0;
   token_beat_t pin_beat = '0;

   // Predictor state.
   state_type  lx_state = ST_START;
   logic [7:0] lx_len   = '0;
   logic [7:0] lx_pfx [PREFIX_DEPTH];

   token_beat_t expected_tokens [$];
   logic [7:0]  text_q [$];
   int          error_count = 0;
   bit          calm        = 1'b0;
   token_beat_t mon_beat;
   token_beat_t mon_want;
   bit          mon_hit;

   string keywords [6] = '{"int", "void", "return", "const", "main", "struct"};
   string ops_double [6] = '{"==", "<=", ">=", "!=", "&&", "||"};
   string ops_bad [4] = '{"!", "&", "|", "+-+"};

   dfa_token_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_valid  (rsp_token_valid),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_code   (rsp_token_code),
      .rsp_token_length (rsp_token_length),
      .rsp_error_code   (rsp_error_code),
      .rsp_end_of_text  (rsp_end_of_text)
   );

   always #5 clock = ~clock;

   // Sort a character into its class.
   function automatic cls_type char_class(input logic [7:0] c);
      if (c == " " || c == "\n" || c == "\t") return CLS_BLANK;
      if (c >= "0" && c <= "9") return CLS_DIGIT;
      if (c == ".") return CLS_DOT;
      if (c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CLS_LETTER;
      if (c == "+" || c == "-" || c == "*" || c == "/" || c == "!" || c == "=" ||
          c == "<" || c == ">" || c == "&" || c == "|") return CLS_OPER;
      if (c == "{" || c == "}" || c == "(" || c == ")" || c == ";" || c == ",")
         return CLS_SEP;
      if (c == "'") return CLS_SQUOTE;
      if (c == "\"") return CLS_DQUOTE;
      if (c == "$") return CLS_EOT;
      return CLS_BAD;
   endfunction

   function automatic void lexer_clear();
      lx_state = ST_START;
      lx_len   = '0;
      foreach (lx_pfx[i]) lx_pfx[i] = '0;
   endfunction

   // Keyword code of the held identifier, or none.
   function automatic logic [4:0] keyword_of();
      logic [47:0] w;
      w = {lx_pfx[0], lx_pfx[1], lx_pfx[2], lx_pfx[3], lx_pfx[4], lx_pfx[5]};
      case (lx_len)
         3: if (w[47:24] == "int") return KW_INT;
         4: begin
            if (w[47:16] == "void") return KW_VOID;
            if (w[47:16] == "main") return KW_MAIN;
         end
         5: if (w[47:8] == "const") return KW_CONST;
         6: begin
            if (w == "return") return KW_RETURN;
            if (w == "struct") return KW_STRUCT;
         end
         default: ;
      endcase
      return CODE_NONE;
   endfunction

   // Operator code of the held text; none means an unknown operator.
   function automatic logic [4:0] operator_of();
      if (lx_len == 1) begin
         case (lx_pfx[0])
            "+": return OP_PLUS;
            "-": return OP_MINUS;
            "*": return OP_STAR;
            "/": return OP_SLASH;
            "%": return OP_PERCENT;
            "=": return OP_ASSIGN;
            ">": return OP_GT;
            "<": return OP_LT;
            default: ;
         endcase
      end else if (lx_len == 2) begin
         case ({lx_pfx[0], lx_pfx[1]})
            "==": return OP_EQ;
            "<=": return OP_LE;
            ">=": return OP_GE;
            "!=": return OP_NE;
            "&&": return OP_AND;
            "||": return OP_OR;
            default: ;
         endcase
      end
      return CODE_NONE;
   endfunction

   function automatic logic [4:0] separator_of();
      if (lx_len == 0) return CODE_NONE;
      case (lx_pfx[0])
         "(": return SEP_LPAREN;
         ")": return SEP_RPAREN;
         "{": return SEP_LBRACE;
         "}": return SEP_RBRACE;
         ";": return SEP_SEMI;
         ",": return SEP_COMMA;
         default: return CODE_NONE;
      endcase
   endfunction

   // Advance the lexer by one character; returns 1 when a result beat is due.
   function automatic bit predict_token(input logic [7:0] c, output token_beat_t beat);
      cls_type    k;
      state_type  cur;
      state_type  nxt;
      bit         closes;
      logic [3:0] kind;
      logic [4:0] code;
      beat = '0;
      kind = KIND_IDENT;
      code = CODE_NONE;
      k = char_class(c);
      if (k == CLS_BAD) begin
         beat.error_code = ERR_BAD_CHAR;
         lexer_clear();
         return 1'b1;
      end
      cur    = lx_state;
      nxt    = TOKEN_NEXT[cur][k];
      closes = TOKEN_CLOSES[cur][k];

      // Work out what the closed token is.
      if (closes) begin
         case (cur)
            ST_IDENT: begin
               code = keyword_of();
               kind = (code != CODE_NONE) ? KIND_KEYWORD : KIND_IDENT;
            end
            ST_INT:   kind = KIND_INT;
            ST_FLOAT: kind = KIND_FLOAT;
            ST_OPER: begin
               code = operator_of();
               if (code == CODE_NONE) begin
                  beat.error_code = ERR_BAD_OPER;
                  lexer_clear();
                  return 1'b1;
               end
               kind = KIND_OPER;
            end
            ST_SEP: begin
               kind = KIND_SEP;
               code = separator_of();
            end
            ST_CHAR_CLOSE: kind = KIND_CHAR;
            ST_STR_CLOSE:  kind = KIND_STRING;
            default:       kind = KIND_DOT;
         endcase
      end
      if (nxt == ST_NONE) begin
         beat.error_code = ERR_NO_TRANS;
         lexer_clear();
         return 1'b1;
      end
      if (closes) begin
         beat.token_valid  = 1'b1;
         beat.token_kind   = kind;
         beat.token_code   = code;
         beat.token_length = lx_len;
         lx_len = '0;
      end
      if (nxt == ST_DONE) begin
         beat.end_of_text = 1'b1;
         lexer_clear();
         return 1'b1;
      end
      lx_state = nxt;

      // Blanks and quotes are not part of the token text.
      if (k != CLS_BLANK && k != CLS_SQUOTE && k != CLS_DQUOTE) begin
         if (lx_len < PREFIX_DEPTH) lx_pfx[lx_len] = c;
         if (lx_len < LEN_CAP) lx_len = lx_len + 8'd1;
      end
      return closes;
   endfunction

   // Mostly short gaps, a few long ones, none during a calm stretch.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // Append one token with random content, now and then malformed or noise.
   task automatic gen_token();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         text_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 18) begin
         add_text(keywords[$urandom_range(0, 5)]);
      end else if (pick < 30) begin
         text_q.push_back(pick_char(LETTERS));
         repeat ($urandom_range(0, 7)) text_q.push_back(pick_char(ALNUM));
      end else if (pick < 40) begin
         repeat ($urandom_range(1, 4)) text_q.push_back(pick_char(DIGITS));
      end else if (pick < 48) begin
         repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(DIGITS));
         text_q.push_back(".");
         repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(DIGITS));
      end else if (pick < 63) begin
         n = $urandom_range(0, 9);
         if (n < 4) text_q.push_back(pick_char(OPS_SINGLE));
         else if (n < 9) add_text(ops_double[$urandom_range(0, 5)]);
         else add_text(ops_bad[$urandom_range(0, 3)]);
      end else if (pick < 75) begin
         text_q.push_back(pick_char(SEPARATORS));
      end else if (pick < 81) begin
         text_q.push_back("'");
         text_q.push_back(pick_char(ALNUM));
         text_q.push_back("'");
      end else if (pick < 88) begin
         text_q.push_back("\"");
         repeat ($urandom_range(0, 8)) text_q.push_back(pick_char(BODY));
         text_q.push_back("\"");
      end else if (pick < 91) begin
         text_q.push_back("$");
      end else if (pick < 95) begin
         text_q.push_back(pick_char(LETTERS));
         text_q.push_back(".");
         text_q.push_back(pick_char(LETTERS));
      end else begin
         repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(BLANKS));
      end
      if ($urandom_range(0, 99) < 60) text_q.push_back(pick_char(BLANKS));
   endtask

   // Present one character beat after a random gap and hold it until accepted.
   task automatic send_char(input logic [7:0] c, input logic pinned, input logic has,
                            input token_beat_t pb);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      pin_on        <= pinned;
      pin_has       <= has;
      pin_beat      <= pb;
      do @(posedge clock); while (!req_ready);
   endtask

   // Result side: runs of ready broken by random stalls.
   initial begin : result_sink
      int hold;
      int gap;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Check each result beat against the oldest expectation, then predict accepted input.
   always @(posedge clock) begin
      if (reset) begin
         lexer_clear();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("result beat arrived with no expected token");
               error_count++;
            end else begin
               mon_want = expected_tokens.pop_front();
               check_field("token_valid", mon_want.token_valid, rsp_token_valid);
               check_field("token_kind", mon_want.token_kind, rsp_token_kind);
               check_field("token_code", mon_want.token_code, rsp_token_code);
               check_field("token_length", mon_want.token_length, rsp_token_length);
               check_field("error_code", mon_want.error_code, rsp_error_code);
               check_field("end_of_text", mon_want.end_of_text, rsp_end_of_text);
            end
         end
         if (req_valid && req_ready) begin
            mon_hit = predict_token(req_char_code, mon_beat);
            if (pin_on) begin
               mon_hit  = pin_has;
               mon_beat = pin_beat;
            end
            if (mon_hit) expected_tokens.push_back(mon_beat);
         end
      end
   end

   // Stimulus: reset, the opening table, long tokens, then random token streams.
   initial begin : stimulus
      int n;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_OPENING; i++)
         send_char(OPENING_ROWS[i].ch, OPENING_ROWS[i].pinned, OPENING_ROWS[i].has_beat,
                   OPENING_ROWS[i].beat);

      // An identifier and a string long enough to saturate the length count.
      n = $urandom_range(256, 300);
      text_q.push_back(pick_char(LETTERS));
      repeat (n) text_q.push_back(pick_char(ALNUM));
      text_q.push_back(" ");
      text_q.push_back("\"");
      repeat ($urandom_range(256, 280)) text_q.push_back(pick_char(BODY));
      text_q.push_back("\"");
      text_q.push_back(";");

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (text_q.size() == 0) gen_token();
         calm = (k >= 700 && k < 950);
         send_char(text_q.pop_front(), 1'b0, 1'b0, NO_BEAT);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // Drain the pipeline, then allow for characters that produce no beat.
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
